// ===== sv/wsd_pkg.sv =====
// Package for the winner-takes-all disparity selector.
// Holds widths, register and mode codes, back-end states and shared structs.
// No dependencies.
package wsd_pkg;

   localparam int COST_BITS      = 16;
   localparam int FRAC_BITS      = 8;
   localparam int DISP_W         = 20;
   localparam int CONF_W         = 16;
   localparam int LAYER_W        = 10;
   localparam int MIN_DISP_W     = 11;
   localparam int MODE_W         = 2;
   localparam int CSR_IDX_W      = 1;
   localparam int CSR_DATA_W     = 11;
   localparam int OFF_W          = 9;
   localparam int DIV_NUM_W      = 32;
   localparam int DIV_DEN_W      = 18;
   localparam int DIV_CNT_W      = 6;
   localparam int MAX_LAYERS_DEF = 256;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISP = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 1'b1;

   localparam logic [MODE_W-1:0] MODE_INT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RAW = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUB,
      ST_SUB_WAIT,
      ST_RAT,
      ST_RAT_WAIT,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [COST_BITS-1:0] best_cost;
      logic [COST_BITS-1:0] second_cost;
      logic [COST_BITS-1:0] third_cost;
      logic [COST_BITS-1:0] cost_before;
      logic [COST_BITS-1:0] cost_after;
      logic [LAYER_W-1:0]   best_layer;
      logic                 after_pending;
   } snap_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_ctrl_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
   } div_stat_type;

endpackage

// ===== sv/wsd_if.sv =====
// Valid/ready channel interfaces for layer costs and disparity results.
// Depends on wsd_pkg.
interface wsd_req_if import wsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [COST_BITS-1:0] cost;
   logic                 last_layer;
   modport source (output valid, cost, last_layer, input ready);
   modport sink   (input valid, cost, last_layer, output ready);
endinterface

interface wsd_rsp_if import wsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DISP_W-1:0] disparity;
   logic [CONF_W-1:0] confidence;
   modport source (output valid, disparity, confidence, input ready);
   modport sink   (input valid, disparity, confidence, output ready);
endinterface

// ===== sv/wsd_fifo.sv =====
// Two-entry queue of per-pixel snapshots between front and back.
// Depends on wsd_pkg.
module wsd_fifo import wsd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  snap_type din,
   input  logic     pop,
   output snap_type dout,
   output logic     full,
   output logic     empty
);
   snap_type   mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= din;
      end
   end

   assign dout  = mem_ff[rd_ff];
   assign full  = cnt_ff == 2'd2;
   assign empty = cnt_ff == 2'd0;
endmodule

// ===== sv/wsd_front.sv =====
// Front end: tracks best, second, third and neighbor costs per layer item,
// pushes a snapshot on the last layer. Depends on wsd_pkg and wsd_if.
module wsd_front import wsd_pkg::*; #(
   parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req,
   input  logic      fifo_full,
   output logic      push,
   output snap_type  snap
);
   localparam int LW = (MAX_LAYERS > 2) ? $clog2(MAX_LAYERS) : 1;
   localparam logic [LW-1:0] LAYER_TOP = LW'(MAX_LAYERS - 1);

   logic [LW-1:0]        layer_ff, layer_in, blayer_ff, blayer_in;
   logic [COST_BITS-1:0] best_ff, best_in, second_ff, second_in, third_ff, third_in;
   logic [COST_BITS-1:0] before_ff, before_in, after_ff, after_in, prev_ff, prev_in;
   logic                 pend_ff, pend_in;
   logic                 accept;
   logic [COST_BITS-1:0] c;

   assign req.ready = ~fifo_full;
   assign accept    = req.valid & req.ready;
   assign c         = req.cost;
   assign push      = accept & req.last_layer;

   always_comb begin
      layer_in  = layer_ff;
      blayer_in = blayer_ff;
      best_in   = best_ff;
      second_in = second_ff;
      third_in  = third_ff;
      before_in = before_ff;
      after_in  = after_ff;
      prev_in   = prev_ff;
      pend_in   = pend_ff;
      if (accept) begin
         if (layer_ff == '0) begin
            best_in   = c;
            second_in = c;
            third_in  = c;
            blayer_in = '0;
            before_in = '0;
            after_in  = '0;
            pend_in   = 1'b0;
         end else begin
            if (pend_ff) begin
               after_in = c;
               pend_in  = 1'b0;
            end
            if (c < best_ff) begin
               third_in  = second_ff;
               second_in = best_ff;
               best_in   = c;
               blayer_in = layer_ff;
               before_in = prev_ff;
               after_in  = '0;
               pend_in   = 1'b1;
            end else if (c < second_ff) begin
               third_in  = second_ff;
               second_in = c;
            end else if (c < third_ff) begin
               third_in = c;
            end
         end
         prev_in = c;
      end
      snap.best_cost     = best_in;
      snap.second_cost   = second_in;
      snap.third_cost    = third_in;
      snap.cost_before   = before_in;
      snap.cost_after    = after_in;
      snap.best_layer    = LAYER_W'(blayer_in);
      snap.after_pending = pend_in;
      if (accept) begin
         if (req.last_layer) begin
            layer_in = '0;
            pend_in  = 1'b0;
         end else if (layer_ff != LAYER_TOP) begin
            layer_in = layer_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layer_ff  <= '0;
         blayer_ff <= '0;
         best_ff   <= '0;
         second_ff <= '0;
         third_ff  <= '0;
         before_ff <= '0;
         after_ff  <= '0;
         prev_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         layer_ff  <= layer_in;
         blayer_ff <= blayer_in;
         best_ff   <= best_in;
         second_ff <= second_in;
         third_ff  <= third_in;
         before_ff <= before_in;
         after_ff  <= after_in;
         prev_ff   <= prev_in;
         pend_ff   <= pend_in;
      end
   end
endmodule

// ===== sv/wsd_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by offset and ratio.
// Depends on wsd_pkg.
module wsd_div import wsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  div_ctrl_type ctrl,
   output div_stat_type stat
);
   logic [DIV_NUM_W-1:0] q_ff, q_in;
   logic [DIV_DEN_W-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [DIV_DEN_W:0]   sh;

   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      sh      = {rem_ff, q_ff[DIV_NUM_W-1]};
      if (ctrl.start) begin
         q_in    = ctrl.num;
         rem_in  = '0;
         den_in  = ctrl.den;
         cnt_in  = DIV_CNT_W'(DIV_NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, den_ff}) begin
            rem_in = DIV_DEN_W'(sh - {1'b0, den_ff});
            q_in   = {q_ff[DIV_NUM_W-2:0], 1'b1};
         end else begin
            rem_in = DIV_DEN_W'(sh);
            q_in   = {q_ff[DIV_NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quot = q_ff;
endmodule

// ===== sv/wsd_back.sv =====
// Back end: per pixel, computes subpixel offset and confidence, on the divider
// where needed, then loads the result register. Depends on wsd_pkg and wsd_if.
module wsd_back import wsd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  snap_type               head,
   input  logic                   fifo_empty,
   output logic                   pop,
   input  logic [MIN_DISP_W-1:0]  min_disp,
   input  logic [MODE_W-1:0]      mode,
   output div_ctrl_type           div_ctrl,
   input  div_stat_type           div_stat,
   wsd_rsp_if.source              rsp
);
   back_state_type       state_ff, state_in;
   snap_type             snap_ff;
   logic [OFF_W-1:0]     off_ff;
   logic                 off_use_ff;
   logic [CONF_W-1:0]    conf_ff;
   logic                 out_valid_ff;
   logic [DISP_W-1:0]    out_disp_ff;
   logic [CONF_W-1:0]    out_conf_ff;

   logic                 interior, refine, neg, need_sub, need_rat, out_free;
   logic [COST_BITS:0]   sum, twice, d;
   logic [COST_BITS-1:0] n, rat_den, raw_conf;
   logic [DISP_W-1:0]    base, disp;

   always_comb begin
      interior = (snap_ff.best_layer != '0) & ~snap_ff.after_pending;
      refine   = (mode != MODE_INT) & interior;
      sum      = {1'b0, snap_ff.cost_after} + {1'b0, snap_ff.cost_before};
      twice    = {snap_ff.best_cost, 1'b0};
      d        = sum - twice;
      neg      = snap_ff.cost_after < snap_ff.cost_before;
      n        = neg ? snap_ff.cost_before - snap_ff.cost_after
                     : snap_ff.cost_after - snap_ff.cost_before;
      need_sub = refine & (sum > twice) & ({2'b00, n} < {d, 1'b0});
      rat_den  = refine ? snap_ff.third_cost : snap_ff.second_cost;
      need_rat = (mode != MODE_RAW) & ~(refine & (snap_ff.best_cost == '0))
               & (rat_den != '0) & (snap_ff.best_cost <= rat_den);
      raw_conf = (mode == MODE_RAW) ? snap_ff.best_cost : '0;
      out_free = ~out_valid_ff | rsp.ready;
      base     = DISP_W'({{(DISP_W-MIN_DISP_W){min_disp[MIN_DISP_W-1]}}, min_disp}
                 + DISP_W'(snap_ff.best_layer));
      disp     = DISP_W'(base << FRAC_BITS);
      if (off_use_ff) begin
         disp = neg ? disp + DISP_W'(off_ff) : disp - DISP_W'(off_ff);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (!fifo_empty) state_in = ST_SUB;
         ST_SUB:      state_in = need_sub ? ST_SUB_WAIT : ST_RAT;
         ST_SUB_WAIT: if (div_stat.done) state_in = ST_RAT;
         ST_RAT:      state_in = need_rat ? ST_RAT_WAIT : ST_EMIT;
         ST_RAT_WAIT: if (div_stat.done) state_in = ST_EMIT;
         ST_EMIT:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      pop            = 1'b0;
      div_ctrl.start = 1'b0;
      div_ctrl.num   = DIV_NUM_W'({n, {FRAC_BITS{1'b0}}}) + DIV_NUM_W'(d);
      div_ctrl.den   = DIV_DEN_W'({d, 1'b0});
      case (state_ff)
         ST_IDLE: pop = ~fifo_empty;
         ST_SUB:  div_ctrl.start = need_sub;
         ST_RAT: begin
            div_ctrl.start = need_rat;
            div_ctrl.num   = DIV_NUM_W'({rat_den - snap_ff.best_cost, 16'h0000});
            div_ctrl.den   = DIV_DEN_W'(rat_den);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_EMIT && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (pop) begin
         snap_ff <= head;
      end
      case (state_ff)
         ST_SUB: off_use_ff <= 1'b0;
         ST_SUB_WAIT: begin
            if (div_stat.done) begin
               off_ff     <= OFF_W'(div_stat.quot);
               off_use_ff <= 1'b1;
            end
         end
         ST_RAT: conf_ff <= raw_conf;
         ST_RAT_WAIT: begin
            if (div_stat.done) begin
               conf_ff <= (div_stat.quot > DIV_NUM_W'(16'hFFFF)) ? '1
                          : CONF_W'(div_stat.quot);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_disp_ff <= disp;
               out_conf_ff <= conf_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.disparity  = out_disp_ff;
   assign rsp.confidence = out_conf_ff;
endmodule

// ===== sv/wta_subpixel_disparity_select.sv =====
// Winner-takes-all disparity select with parabolic subpixel refinement.
// Depends on wsd_pkg, wsd_if, wsd_fifo, wsd_front, wsd_div, wsd_back.
//
//   port  dir  payload                         accepted when
//   req   in   cost[15:0], last_layer          valid && ready
//   rsp   out  disparity[19:0], confidence     valid && ready
//   csr   in   csr_index, csr_wdata[10:0]      csr_we
//
// Layer items enter one per cycle while the two-entry snapshot queue has room.
// The back end takes one pixel at a time and runs the bit-serial divider (one
// quotient bit per cycle) up to twice per pixel, once for the offset and once
// for the confidence. Synchronous active-high reset clears all control.
// A stalled rsp holds its register; the queue then fills and req stalls.
module wta_subpixel_disparity_select import wsd_pkg::*; #(
   parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   wsd_req_if.sink               req,
   wsd_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
   logic [MIN_DISP_W-1:0] min_disp_ff;
   logic [MODE_W-1:0]     mode_ff;
   logic                  push, pop, fifo_full, fifo_empty;
   snap_type              snap_in, head;
   div_ctrl_type          div_ctrl;
   div_stat_type          div_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_disp_ff <= '0;
         mode_ff     <= MODE_INT;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MIN_DISP: min_disp_ff <= MIN_DISP_W'(csr_wdata);
            CSR_MODE:     mode_ff     <= MODE_W'(csr_wdata);
            default: ;
         endcase
      end
   end

   wsd_front #(.MAX_LAYERS(MAX_LAYERS)) u_front (
      .clock(clock), .reset(reset), .req(req),
      .fifo_full(fifo_full), .push(push), .snap(snap_in)
   );

   wsd_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .din(snap_in),
      .pop(pop), .dout(head), .full(fifo_full), .empty(fifo_empty)
   );

   wsd_div u_div (
      .clock(clock), .reset(reset), .ctrl(div_ctrl), .stat(div_stat)
   );

   wsd_back u_back (
      .clock(clock), .reset(reset), .head(head), .fifo_empty(fifo_empty),
      .pop(pop), .min_disp(min_disp_ff), .mode(mode_ff),
      .div_ctrl(div_ctrl), .div_stat(div_stat), .rsp(rsp)
   );

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !fifo_full)
      else $error("snapshot pushed into full queue");

   a_pop_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_empty)
      else $error("snapshot popped from empty queue");

   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_ctrl.start |-> !div_stat.busy)
      else $error("divider restarted while busy");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> $past(div_stat.busy))
      else $error("divider done without a run");
endmodule

// ===== tb/sv/wta_subpixel_disparity_select_tb.sv =====
// Testbench for the winner-takes-all disparity selector with subpixel refinement.
// Drives layer costs through wsd_req_if, checks results on wsd_rsp_if against a
// behavioral predictor. Depends on wsd_pkg, wsd_if and the block.
module wta_subpixel_disparity_select_tb;
   import wsd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DISP_W-1:0] disparity;
      logic [CONF_W-1:0] confidence;
   } disp_result_type;

   typedef struct {
      logic [COST_BITS-1:0] cost;
      logic                 last_layer;
      logic                 typed;
      logic [DISP_W-1:0]    disparity;
      logic [CONF_W-1:0]    confidence;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wsd_req_if req ();
   wsd_rsp_if rsp ();

   wta_subpixel_disparity_select DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   int                   cfg_min_disp;
   logic [MODE_W-1:0]    cfg_mode;
   int unsigned          layer_idx;
   logic [COST_BITS-1:0] best_c, second_c, third_c, before_c, after_c, prev_c;
   int unsigned          best_idx;
   logic                 after_wait;

   disp_result_type expected_q[$];
   int  mismatch_count = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  idle_cycles = 0;
   bit  timed_out = 0;
   bit  sending = 0;
   logic [COST_BITS-1:0] next_cost;
   logic                 next_last;

   localparam int WATCHDOG_LIMIT = 5000;

   function automatic logic [CONF_W-1:0] cost_ratio(longint unsigned den,
                                                    longint unsigned low);
      longint unsigned v;
      if (den == 0 || low > den) return '0;
      v = ((den - low) << 16) / den;
      return (v > 65535) ? 16'hFFFF : v[15:0];
   endfunction

   task automatic predict_layer(input logic [COST_BITS-1:0] c, input logic last);
      bit interior, subpix;
      longint disp;
      longint unsigned sum, twice, d, n, q;
      logic [CONF_W-1:0] conf;
      disp_result_type r;
      if (layer_idx == 0) begin
         best_c = c; second_c = c; third_c = c; best_idx = 0;
         before_c = '0; after_c = '0; after_wait = 1'b0;
      end else begin
         if (after_wait) begin
            after_c = c;
            after_wait = 1'b0;
         end
         if (c < best_c) begin
            third_c = second_c; second_c = best_c; best_c = c;
            best_idx = layer_idx; before_c = prev_c; after_c = '0; after_wait = 1'b1;
         end else if (c < second_c) begin
            third_c = second_c; second_c = c;
         end else if (c < third_c) begin
            third_c = c;
         end
      end
      prev_c = c;
      if (!last) begin
         if (layer_idx < MAX_LAYERS_DEF - 1) layer_idx++;
         return;
      end
      interior = best_idx != 0 && !after_wait;
      subpix = cfg_mode != MODE_INT;
      disp = longint'(cfg_min_disp + int'(best_idx)) * (longint'(1) << FRAC_BITS);
      if (subpix && interior) begin
         sum = longint'(after_c) + longint'(before_c);
         twice = longint'(best_c) << 1;
         if (sum > twice) begin
            d = sum - twice;
            n = (after_c < before_c) ? before_c - after_c : after_c - before_c;
            if (n < (d << 1)) begin
               q = ((n << FRAC_BITS) + d) / (d << 1);
               if (after_c < before_c) disp += longint'(q);
               else disp -= longint'(q);
            end
         end
      end
      if (cfg_mode == MODE_RAW) conf = best_c;
      else if (subpix && interior) conf = (best_c == 0) ? '0 : cost_ratio(third_c, best_c);
      else conf = cost_ratio(second_c, best_c);
      r.disparity = disp[DISP_W-1:0];
      r.confidence = conf;
      expected_q.push_back(r);
      layer_idx = 0;
      after_wait = 1'b0;
   endtask

   // accepted items on both sides; watchdog
   always @(posedge clock) begin
      disp_result_type exp_r;
      if (!reset) begin
         if (req.valid && req.ready) predict_layer(req.cost, req.last_layer);
         if (rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result disp=%h conf=%h", rsp.disparity,
                           rsp.confidence);
            end else begin
               exp_r = expected_q.pop_front();
               if (exp_r.disparity !== rsp.disparity ||
                   exp_r.confidence !== rsp.confidence) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: exp disp=%h conf=%h, got disp=%h conf=%h",
                              exp_r.disparity, exp_r.confidence, rsp.disparity,
                              rsp.confidence);
               end
            end
         end
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // drive one item; valid stays high across back-to-back items
   task automatic send_layer(input logic [COST_BITS-1:0] c, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.cost <= c;
      req.last_layer <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (expected_q.size() != 0 && idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_MIN_DISP) cfg_min_disp = $signed(val);
      else cfg_mode = val[MODE_W-1:0];
      @(posedge clock);
   endtask

   task automatic random_pixel();
      int n, base, kind, i;
      logic [COST_BITS-1:0] c;
      kind = $urandom_range(9);
      n = (kind == 0) ? $urandom_range(260, 300) : $urandom_range(1, 12);
      base = $urandom_range(65535);
      for (i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: c = COST_BITS'($urandom_range(65535));
            1: c = COST_BITS'(base);
            2: c = COST_BITS'((base > 4000) ? base - $urandom_range(4000)
                                            : $urandom_range(4000));
            default: c = COST_BITS'($urandom_range(1) ? 16'hFFFF : $urandom_range(3));
         endcase
         send_layer(c, i == n - 1);
      end
   endtask

   stim_row_type directed[] = '{
      '{16'd0,     1'b1, 1'b1, 20'h00000, 16'h0000},
      '{16'hFFFF,  1'b1, 1'b1, 20'h00000, 16'h0000},
      '{16'd100,   1'b0, 1'b0, '0, '0},
      '{16'd50,    1'b1, 1'b1, 20'h00100, 16'h8000},
      '{16'd30,    1'b0, 1'b0, '0, '0},
      '{16'd30,    1'b0, 1'b0, '0, '0},
      '{16'd30,    1'b1, 1'b1, 20'h00000, 16'h0000},
      '{16'd0,     1'b0, 1'b0, '0, '0},
      '{16'hFFFF,  1'b1, 1'b1, 20'h00000, 16'h0000},
      '{16'd40,    1'b0, 1'b0, '0, '0},
      '{16'd10,    1'b0, 1'b0, '0, '0},
      '{16'd20,    1'b1, 1'b0, '0, '0},
      '{16'd10,    1'b0, 1'b0, '0, '0},
      '{16'd0,     1'b0, 1'b0, '0, '0},
      '{16'd10,    1'b1, 1'b0, '0, '0},
      '{16'd500,   1'b0, 1'b0, '0, '0},
      '{16'd100,   1'b0, 1'b0, '0, '0},
      '{16'd100,   1'b1, 1'b0, '0, '0},
      '{16'd9,     1'b0, 1'b0, '0, '0},
      '{16'd1,     1'b0, 1'b0, '0, '0},
      '{16'd100,   1'b1, 1'b0, '0, '0}
   };

   initial begin
      int i, k, modes_done;
      disp_result_type typed_r;
      req.valid = 1'b0;
      req.cost = '0;
      req.last_layer = 1'b0;
      cfg_min_disp = 0; cfg_mode = MODE_INT; layer_idx = 0; after_wait = 0;
      best_c = '0; second_c = '0; third_c = '0; before_c = '0; after_c = '0;
      prev_c = '0; best_idx = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fork
         begin
            for (modes_done = 0; modes_done < 3; modes_done++) begin
               write_reg(CSR_MODE, CSR_DATA_W'(modes_done));
               for (i = 0; i < directed.size(); i++) begin
                  if (directed[i].typed && modes_done == 0) begin
                     typed_r.disparity = directed[i].disparity;
                     typed_r.confidence = directed[i].confidence;
                  end
                  send_layer(directed[i].cost, directed[i].last_layer);
                  if (directed[i].typed && modes_done == 0) begin
                     req.valid <= 1'b0;
                     @(posedge clock);
                     if (expected_q.size() == 0 || expected_q[$] !== typed_r) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                           $display("directed row %0d: exp disp=%h conf=%h", i,
                                    typed_r.disparity, typed_r.confidence);
                     end
                  end
               end
               drain();
            end
            for (k = 0; k < 9; k++) begin
               case (k / 3)
                  0: begin send_idle_pct = 21; recv_idle_pct = 56; end
                  1: begin send_idle_pct = 56; recv_idle_pct = 21; end
                  default: begin send_idle_pct = 0; recv_idle_pct = 0; end
               endcase
               write_reg(CSR_MODE, CSR_DATA_W'((k < 6) ? $urandom_range(3) : k - 6));
               case (k)
                  0: write_reg(CSR_MIN_DISP, 11'h400);
                  1: write_reg(CSR_MIN_DISP, 11'h3FF);
                  default: write_reg(CSR_MIN_DISP, CSR_DATA_W'($urandom_range(2047)));
               endcase
               i = 0;
               while (i < 4) begin
                  random_pixel();
                  i++;
               end
               drain();
            end
         end
         begin
            while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
            timed_out = 1;
         end
      join_any

      if (timed_out) begin
         $display("wta_subpixel_disparity_select_tb: done, errors");
      end else if (mismatch_count == 0 && expected_q.size() == 0) begin
         $display("wta_subpixel_disparity_select_tb: done, clean");
      end else begin
         $display("wta_subpixel_disparity_select_tb: done, errors");
      end
      $finish;
   end
endmodule
